>>> hw/rtl/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg
// Shared types for the dual stack: operation and status codes, sequencer
// states and the memory control group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dst_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned FILL_W   = 9;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_PEEK     = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_OVERTURN = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/dst_if.sv
// ----------------------------------------------------------------------------
// dst_if
// Valid/ready channels for stack requests and their results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dst_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic               stack_sel;
  logic signed [31:0] push_value;

  modport source (output valid, output op, output stack_sel, output push_value,
                  input ready);
  modport sink   (input valid, input op, input stack_sel, input push_value,
                  output ready);
endinterface

interface dst_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] top_value;
  logic [1:0]         status;
  logic [8:0]         fill_level;

  modport source (output valid, output top_value, output status, output fill_level,
                  input ready);
  modport sink   (input valid, input top_value, input status, input fill_level,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dst_mem.sv
// ----------------------------------------------------------------------------
// dst_mem
// Shared stack store: one write port, one read port, registered read data
// that holds while no read is issued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dst_mem #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned ADDR_WIDTH = 9
) (
  input  wire logic                  clk,
  input  wire dst_pkg::mem_ctl_t     ctl,
  input  wire logic [ADDR_WIDTH-1:0] waddr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic [ADDR_WIDTH-1:0] raddr,
  output logic      [DATA_WIDTH-1:0] rdata
);
  import dst_pkg::*;

  localparam int unsigned WORDS = 2 ** ADDR_WIDTH;

  logic [DATA_WIDTH-1:0] mem_r [WORDS];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/dst_ctrl.sv
// ----------------------------------------------------------------------------
// dst_ctrl
// Request sequencer: holds both fill counts, drives the store and walks the
// overturn one entry per cycle, the last once the result register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dst_ctrl #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX_WIDTH  = 8,
  parameter int unsigned CNT_WIDTH  = 9
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  dst_in_if.sink                     in_chan,
  dst_out_if.source                  out_chan,
  output dst_pkg::mem_ctl_t          mem_ctl,
  output logic [IDX_WIDTH:0]         mem_waddr,
  output logic [DATA_WIDTH-1:0]      mem_wdata,
  output logic [IDX_WIDTH:0]         mem_raddr,
  input  wire logic [DATA_WIDTH-1:0] mem_rdata
);
  import dst_pkg::*;

  localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);
  localparam logic [CNT_WIDTH-1:0] CNT_ONE  = CNT_WIDTH'(1);
  localparam logic [CNT_WIDTH-1:0] CNT_TWO  = CNT_WIDTH'(2);

  state_t                state_r, state_nxt;
  op_t                   op_r;
  logic                  sel_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CNT_WIDTH-1:0]  cnt_r [2];
  logic [CNT_WIDTH-1:0]  cnt_nxt [2];

  logic                  out_valid_r;
  logic [VALUE_W-1:0]    top_r, top_nxt;
  status_t               status_r, status_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;

  logic                  accept;
  logic                  out_free;
  logic                  finish;
  logic                  commit;
  logic                  want_wr;
  logic                  want_rd;
  logic [CNT_WIDTH-1:0]  src_cnt, dst_cnt, src_dec, acc_cnt, acc_dec;
  logic [CNT_WIDTH-1:0]  src_new, dst_new;
  logic signed [63:0]    push_wide;
  logic signed [63:0]    read_wide;

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign src_cnt = cnt_r[sel_r];
  assign dst_cnt = cnt_r[!sel_r];
  assign src_dec = src_cnt - CNT_ONE;
  assign acc_cnt = cnt_r[in_chan.stack_sel];
  assign acc_dec = acc_cnt - CNT_ONE;

  // Push values are sign-extended and cut to the stored width; read words
  // come back sign-extended and are reported as their low 32 bits.
  assign push_wide = 64'(in_chan.push_value);
  assign read_wide = 64'(signed'(mem_rdata));

  always_comb begin
    finish     = 1'b0;
    want_wr    = 1'b0;
    want_rd    = 1'b0;
    src_new    = src_cnt;
    dst_new    = dst_cnt;
    top_nxt    = '0;
    status_nxt = ST_OK;
    mem_waddr  = {sel_r, src_cnt[IDX_WIDTH-1:0]};
    mem_wdata  = val_r;
    mem_raddr  = {in_chan.stack_sel, acc_dec[IDX_WIDTH-1:0]};

    if (state_r == S_EXEC) begin
      unique case (op_r)
        OP_PUSH: begin
          finish = 1'b1;
          if (src_cnt == CNT_FULL) begin
            status_nxt = ST_FULL;
          end else begin
            want_wr = 1'b1;
            src_new = src_cnt + CNT_ONE;
          end
        end
        OP_POP, OP_PEEK: begin
          finish = 1'b1;
          if (src_cnt == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            top_nxt = read_wide[VALUE_W-1:0];
            if (op_r == OP_POP) begin
              src_new = src_dec;
            end
          end
        end
        OP_CLEAR: begin
          finish  = 1'b1;
          src_new = '0;
        end
        OP_OVERTURN: begin
          mem_waddr = {!sel_r, dst_cnt[IDX_WIDTH-1:0]};
          mem_wdata = mem_rdata;
          mem_raddr = {sel_r, IDX_WIDTH'(src_cnt - CNT_TWO)};
          if (src_cnt == '0) begin
            finish     = 1'b1;
            status_nxt = ST_EMPTY;
          end else if (dst_cnt == CNT_FULL) begin
            finish     = 1'b1;
            status_nxt = ST_FULL;
          end else begin
            // Move the current top; fetch the next one unless this was the last.
            want_wr = 1'b1;
            src_new = src_dec;
            dst_new = dst_cnt + CNT_ONE;
            if (src_dec == '0) begin
              finish = 1'b1;
            end else begin
              want_rd = 1'b1;
            end
          end
        end
        default: begin
          finish = 1'b1;
        end
      endcase
    end

    fill_nxt = FILL_W'(src_new);
  end

  // A finishing step waits while the previous result is still held.
  assign commit = (state_r == S_EXEC) && (!finish || out_free);

  always_comb begin
    mem_ctl.wr_en = commit && want_wr;
    mem_ctl.rd_en = accept || (commit && want_rd);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (commit) begin
      cnt_nxt[sel_r]  = src_new;
      cnt_nxt[!sel_r] = dst_new;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit && finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_chan.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r[0] <= cnt_nxt[0];
      cnt_r[1] <= cnt_nxt[1];
      if (commit && finish) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_chan.op);
      sel_r <= in_chan.stack_sel;
      val_r <= push_wide[DATA_WIDTH-1:0];
    end
    if (commit && finish) begin
      top_r    <= top_nxt;
      status_r <= status_nxt;
      fill_r   <= fill_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.top_value  = top_r;
  assign out_chan.status     = status_r;
  assign out_chan.fill_level = fill_r;

endmodule

`default_nettype wire

>>> hw/rtl/dual_stack_with_transfer.sv
// ----------------------------------------------------------------------------
// dual_stack_with_transfer
// Two LIFO stacks in one shared store with push, pop, peek, clear and an
// overturn that moves the entries of one stack onto the other.
// Push, pop, peek, clear: each request is accepted, then finished in the
// execute state, where pop and peek use the top-of-stack read from the store.
// Overturn: one entry moves per cycle, the final move waiting while the prior
// result is still held; it stops on an empty source or a full stack.
// Results are registered and appear the cycle after execution.
// Reset clears both fill counts; the store itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_stack_with_transfer #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dst_in_if.sink    in_chan,
  dst_out_if.source out_chan
);
  import dst_pkg::*;

  localparam int unsigned IDX_WIDTH = $clog2(DEPTH);
  localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);

  mem_ctl_t              mem_ctl;
  logic [IDX_WIDTH:0]    mem_waddr;
  logic [IDX_WIDTH:0]    mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;

  dst_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_WIDTH  (IDX_WIDTH),
    .CNT_WIDTH  (CNT_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .mem_ctl   (mem_ctl),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  dst_mem #(
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_WIDTH (IDX_WIDTH + 1)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual stack. Requests go from a queue to a
// valid/ready driver, and results are checked against a predictor of both
// stacks. Coverage comes from a directed opening, bursts of random pushes,
// pops and transfers, and a run that fills the stacks to capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dst_pkg::*;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned LONG_HOLD_CYCLES = 200;

  // Op codes the block does not define; they must leave the stacks alone.
  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic                sel;
    logic signed [31:0]  value;
  } stack_request_t;

  typedef struct {
    logic signed [31:0]  top_value;
    status_t             status;
    logic [FILL_W-1:0]   fill_level;
  } stack_result_t;

  logic clk;
  logic rst_n;

  dst_in_if  in_if ();
  dst_out_if out_if ();

  dual_stack_with_transfer #(
    .DEPTH      (STACK_DEPTH),
    .DATA_WIDTH (32)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  stack_request_t pending_requests[$];
  stack_result_t  awaited_results[$];

  logic [31:0]  stack_words [2][STACK_DEPTH];
  int unsigned  stack_fill [2];

  int unsigned requests_planned;
  int unsigned requests_accepted;
  int unsigned results_seen;
  int unsigned empty_seen;
  int unsigned full_seen;
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  logic        long_hold_done;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the predicted stacks and returns its result.
  function automatic stack_result_t execute_on_stacks(logic [OP_W-1:0] op, logic sel,
                                                      logic [31:0] value);
    stack_result_t r;
    int            s;
    int            o;
    logic          moving;
    s = int'(sel);
    o = 1 - s;
    r.top_value = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (stack_fill[s] >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_words[s][stack_fill[s]] = value;
          stack_fill[s]++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (stack_fill[s] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.top_value = stack_words[s][stack_fill[s] - 1];
          if (op == OP_POP) stack_fill[s]--;
        end
      end
      OP_CLEAR: begin
        stack_fill[s] = 0;
      end
      OP_OVERTURN: begin
        if (stack_fill[s] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          moving = 1'b1;
          while (moving && stack_fill[s] != 0) begin
            if (stack_fill[o] >= STACK_DEPTH) begin
              r.status = ST_FULL;
              moving = 1'b0;
            end else begin
              stack_words[o][stack_fill[o]] = stack_words[s][stack_fill[s] - 1];
              stack_fill[o]++;
              stack_fill[s]--;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.fill_level = FILL_W'(stack_fill[s]);
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_8000;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_request(logic [OP_W-1:0] op, logic sel, logic [31:0] value);
    stack_request_t req;
    req.op = op;
    req.sel = sel;
    req.value = value;
    pending_requests.push_back(req);
    requests_planned++;
  endtask

  task automatic push_run(logic sel, int unsigned count);
    repeat (count) begin
      if ($urandom_range(5) == 0) add_request(OP_PEEK, sel, $urandom());
      else add_request(OP_PUSH, sel, pick_value());
    end
  endtask

  task automatic pop_run(logic sel, int unsigned count);
    repeat (count) begin
      if ($urandom_range(3) == 0) add_request(OP_PEEK, sel, $urandom());
      else add_request(OP_POP, sel, $urandom());
    end
  endtask

  // Mostly push and pop bursts so the stacks build real depth; a share of
  // transfers, clears and raw noise over all eight op codes.
  task automatic random_until(int unsigned target);
    logic sel;
    while (requests_planned < target) begin
      sel = 1'($urandom_range(1));
      case ($urandom_range(9))
        0, 1, 2, 3: push_run(sel, $urandom_range(1, 16));
        4, 5: pop_run(sel, $urandom_range(1, 12));
        6: add_request(OP_OVERTURN, sel, $urandom());
        7: add_request(OP_CLEAR, sel, $urandom());
        default: begin
          repeat (6) add_request(OP_W'($urandom_range(7)), 1'($urandom_range(1)),
                                 pick_value());
        end
      endcase
    end
  endtask

  task automatic wait_until_settled();
    while (pending_requests.size() != 0 || awaited_results.size() != 0 || in_if.valid)
      @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_requests
    stack_request_t next_req;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        awaited_results.push_back(
          execute_on_stacks(in_if.op, in_if.stack_sel, in_if.push_value));
        requests_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_requests.pop_front();
          in_if.valid <= 1'b1;
          in_if.op <= next_req.op;
          in_if.stack_sel <= next_req.sel;
          in_if.push_value <= next_req.value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    stack_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: top_value %0d status %0d fill_level %0d",
                 out_if.top_value, out_if.status, out_if.fill_level);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (want.status == ST_EMPTY) empty_seen++;
          if (want.status == ST_FULL) full_seen++;
          if (out_if.top_value !== want.top_value) begin
            $error("top_value expected %0d got %0d", want.top_value, out_if.top_value);
            mismatch_count++;
          end
          if (out_if.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_if.status);
            mismatch_count++;
          end
          if (out_if.fill_level !== want.fill_level) begin
            $error("fill_level expected %0d got %0d", want.fill_level, out_if.fill_level);
            mismatch_count++;
          end
        end
      end
      // One long back-pressure stretch early on, so the block backs up and
      // holds off new requests while the driver keeps offering.
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!long_hold_done && results_seen >= 40) begin
        out_if.ready <= 1'b0;
        hold_left <= LONG_HOLD_CYCLES;
        long_hold_done <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_PUSH;
    in_if.stack_sel = 1'b0;
    in_if.push_value = '0;
    out_if.ready = 1'b0;
    quiet_cycles = 0;
    stack_fill[0] = 0;
    stack_fill[1] = 0;
    requests_planned = 0;
    requests_accepted = 0;
    results_seen = 0;
    empty_seen = 0;
    full_seen = 0;
    mismatch_count = 0;
    send_idle_pct = 9;
    recv_idle_pct = 50;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty stacks first, then the value extremes and every op code.
    add_request(OP_PEEK, 1'b0, $urandom());
    add_request(OP_POP, 1'b1, $urandom());
    add_request(OP_CLEAR, 1'b0, $urandom());
    add_request(OP_OVERTURN, 1'b0, $urandom());
    add_request(OP_PUSH, 1'b0, 32'h7fff_ffff);
    add_request(OP_PUSH, 1'b0, 32'h8000_0000);
    add_request(OP_PUSH, 1'b0, 32'hffff_8000);
    add_request(OP_PUSH, 1'b0, 32'h0000_0000);
    add_request(OP_PUSH, 1'b0, 32'hffff_ffff);
    add_request(OP_PEEK, 1'b0, $urandom());
    add_request(OP_POP, 1'b0, $urandom());
    add_request(OP_POP, 1'b0, $urandom());
    add_request(OP_OVERTURN, 1'b0, $urandom());
    add_request(OP_PEEK, 1'b1, $urandom());
    add_request(OP_POP, 1'b1, $urandom());
    add_request(OP_RSVD_5, 1'b0, $urandom());
    add_request(OP_RSVD_6, 1'b1, $urandom());
    add_request(OP_RSVD_7, 1'b0, $urandom());
    add_request(OP_PUSH, 1'b1, 32'h0000_0001);
    add_request(OP_CLEAR, 1'b1, $urandom());
    add_request(OP_PEEK, 1'b1, $urandom());
    add_request(OP_PUSH, 1'b0, $urandom());
    add_request(OP_PUSH, 1'b1, $urandom());
    add_request(OP_OVERTURN, 1'b1, $urandom());
    random_until(200);
    wait_until_settled();

    send_idle_pct = 50;
    recv_idle_pct = 9;
    random_until(360);
    wait_until_settled();

    // Full-stack behavior: pushes dropped at capacity and transfers that
    // stop part way when the receiving stack fills.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_request(OP_CLEAR, 1'b0, $urandom());
    add_request(OP_CLEAR, 1'b1, $urandom());
    repeat (250) add_request(OP_PUSH, 1'b1, pick_value());
    repeat (10) add_request(OP_PUSH, 1'b0, pick_value());
    add_request(OP_OVERTURN, 1'b0, $urandom());
    add_request(OP_PUSH, 1'b1, pick_value());
    add_request(OP_PUSH, 1'b1, pick_value());
    add_request(OP_POP, 1'b1, $urandom());
    add_request(OP_PEEK, 1'b1, $urandom());
    add_request(OP_OVERTURN, 1'b1, $urandom());
    add_request(OP_PUSH, 1'b0, pick_value());
    add_request(OP_POP, 1'b0, $urandom());
    add_request(OP_OVERTURN, 1'b0, $urandom());
    add_request(OP_PEEK, 1'b0, $urandom());
    random_until(650);
    wait_until_settled();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests under three flow-control mixes; %0d results checked,",
             requests_accepted, results_seen);
    $display("%0d of them empty-stack and %0d full-stack outcomes.", empty_seen, full_seen);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> dual_stack_with_transfer.f
hw/rtl/dst_pkg.sv
hw/rtl/dst_if.sv
hw/rtl/dst_mem.sv
hw/rtl/dst_ctrl.sv
hw/rtl/dual_stack_with_transfer.sv
tb/testbench.sv
